// ----- rtl/core/ibus_pkg.sv -----
// Shared constants and types for the iBUS servo frame receiver.
// No dependencies; imported by every module under rtl/core.
package ibus_pkg;

  localparam int NumChannels = 14;
  localparam int ChanW       = 12;
  localparam int IdxW        = 4;
  localparam int CountW      = 5;

  localparam logic [7:0]        SYNC_FIRST  = 8'h20;
  localparam logic [7:0]        SYNC_SECOND = 8'h40;
  localparam logic [15:0]       CHECK_INIT  = 16'hff9f;
  localparam logic [CountW-1:0] IDLE_COUNT  = 5'd30;
  localparam logic [CountW-1:0] CHECK_COUNT = 5'd29;
  localparam logic [IdxW-1:0]   LAST_INDEX  = 4'd13;

  typedef logic [ChanW-1:0] chan_t;
  typedef chan_t [NumChannels-1:0] frame_t;

endpackage

// ----- rtl/core/ibus_parse.sv -----
// Byte-level frame parser: sync detect, pair counter, checksum and channel store.
// Depends on ibus_pkg.
module ibus_parse
  import ibus_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,      // byte accepted this cycle
  input  logic [7:0] rx_byte,
  input  logic       busy,      // output buffer still draining
  output logic       idle_safe, // next byte cannot commit a frame
  output logic       commit,
  output frame_t     frame
);

  logic [7:0]        newer_byte;
  logic [CountW-1:0] pair_count;
  logic [CountW-1:0] pair_count_next;
  logic [15:0]       checksum_acc;
  chan_t             store [NumChannels];
  logic              sync_hit;
  logic [15:0]       word;
  logic [IdxW-1:0]   wr_idx;
  logic              wr_en;
  logic              chk_en;

  assign sync_hit  = (newer_byte == SYNC_FIRST) && (rx_byte == SYNC_SECOND);
  assign word      = {rx_byte, newer_byte};
  assign idle_safe = (pair_count != CHECK_COUNT);
  assign wr_idx    = pair_count_next[IdxW:1] - 4'd1;

  always_comb begin
    pair_count_next = pair_count;
    wr_en  = 1'b0;
    chk_en = 1'b0;
    if (sync_hit) begin
      pair_count_next = '0;
    end else if (pair_count >= IDLE_COUNT) begin
      pair_count_next = IDLE_COUNT;
    end else begin
      pair_count_next = pair_count + 5'd1;
      if (!pair_count_next[0]) begin
        if (pair_count_next == IDLE_COUNT) begin
          chk_en = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
    end
  end

  assign commit = take && chk_en && (checksum_acc == word);

  always_ff @(posedge clk) begin
    if (rst) begin
      newer_byte   <= '0;
      pair_count   <= IDLE_COUNT;
      checksum_acc <= '0;
    end else if (take) begin
      newer_byte <= rx_byte;
      pair_count <= pair_count_next;
      if (sync_hit) begin
        checksum_acc <= CHECK_INIT;
      end else if (wr_en) begin
        checksum_acc <= checksum_acc - {8'd0, newer_byte} - {8'd0, rx_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      store[wr_idx] <= word[ChanW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NumChannels; i++) begin
      frame[i] = store[i];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pair_count <= IDLE_COUNT)
    else $error("pair counter out of range");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    commit |-> !busy)
    else $error("frame committed while output buffer busy");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    commit |=> pair_count == IDLE_COUNT)
    else $error("parser not idle after commit");

  a_sync_load: assert property (@(posedge clk) disable iff (rst)
    (take && sync_hit) |=> (pair_count == '0) && (checksum_acc == CHECK_INIT))
    else $error("sync did not restart frame");

endmodule

// ----- rtl/core/ibus_burst.sv -----
// Output buffer: captures a committed frame and plays out its 14 channel words.
// Depends on ibus_pkg.
module ibus_burst
  import ibus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        commit,
  input  frame_t      frame,
  output logic        busy,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [3:0] channel_index, [15:4] channel_value
  output logic        m_tlast   // last
);

  chan_t           obuf [NumChannels];
  logic [IdxW-1:0] idx;
  logic            fire;

  assign fire     = m_tvalid && m_tready;
  assign m_tvalid = busy;
  assign m_tlast  = (idx == LAST_INDEX);
  assign m_tdata  = {obuf[idx], idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (commit) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      if (m_tlast) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < NumChannels; i++) begin
        obuf[i] <= frame[i];
      end
    end
  end

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(fire && m_tlast))
    else $error("burst ended before last channel");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !busy |-> idx == '0)
    else $error("channel index moved while idle");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && !m_tready) |=> $stable(idx))
    else $error("channel index advanced under stall");

endmodule

// ----- rtl/core/ibus_servo_frame_receiver.sv -----
// Top level of the iBUS servo frame receiver: byte stream in, channel words out.
// Depends on ibus_pkg, ibus_parse and ibus_burst.
//
//  channel | dir | tdata                              | tuser | tlast
//  s_*     | in  | [7:0] rx_byte                      | -     | -
//  m_*     | out | [3:0] channel_index, [15:4] value  | -     | last
//
// One byte per cycle while s_tready is high; the byte updates parser state in the cycle it is taken.
// A good checksum pair loads the output buffer, which then sends 14 words,
// one per cycle while m_tready is high.
// Bytes keep flowing during the burst; only the checksum-pair byte waits
// while a previous frame is still draining.
// Reset (rst, synchronous): parser idle awaiting sync, output buffer empty.
module ibus_servo_frame_receiver
  import ibus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [3:0] channel_index, [15:4] channel_value
  output logic        m_tlast   // last
);

  logic   take;
  logic   busy;
  logic   idle_safe;
  logic   commit;
  frame_t frame;

  // hold the checksum byte while the buffer still owns a frame
  assign s_tready = !busy || idle_safe;
  assign take     = s_tvalid && s_tready;

  ibus_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (s_tdata),
    .busy      (busy),
    .idle_safe (idle_safe),
    .commit    (commit),
    .frame     (frame)
  );

  ibus_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .commit   (commit),
    .frame    (frame),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- sim/ibus_servo_frame_receiver_test.sv -----
// Testbench for ibus_servo_frame_receiver: drives serial bytes, predicts decoded channel words.
// Depends on ibus_pkg and the receiver RTL; self-checking, no external files.
`timescale 1ns / 100ps

module ibus_servo_frame_receiver_test;
  import ibus_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 30;

  typedef struct packed {
    logic [IdxW-1:0] index;
    chan_t           value;
    logic            is_last;
  } chan_word_t;

  typedef logic [NumChannels-1:0][15:0] frame_words_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [3:0] channel_index, [15:4] channel_value
  logic        m_tlast;           // last

  // Decoder image: byte history, frame position and checksum since sync.
  logic [7:0]        prev_byte = 8'h00;
  logic [7:0]        newest_byte = 8'h00;
  logic [CountW-1:0] frame_pos = IDLE_COUNT;
  logic [15:0]       running_sum = 16'h0000;
  chan_t             channel_image [NumChannels];

  chan_word_t pending_channels [$];

  int err_count = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_request = 1'b0;

  ibus_servo_frame_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Advance the decoder image by one accepted byte; queue a full frame on a good checksum.
  function automatic void decode_byte(input logic [7:0] rx);
    logic [15:0] word;
    chan_word_t  exp_word;
    int          ch;
    prev_byte   = newest_byte;
    newest_byte = rx;
    if (prev_byte == SYNC_FIRST && newest_byte == SYNC_SECOND) begin
      frame_pos   = '0;
      running_sum = CHECK_INIT;
      return;
    end
    if (frame_pos >= IDLE_COUNT) begin
      frame_pos = IDLE_COUNT;
      return;
    end
    frame_pos = frame_pos + 1'b1;
    if (frame_pos[0]) return;
    word = {newest_byte, prev_byte};
    if (frame_pos == IDLE_COUNT) begin
      if (running_sum == word) begin
        for (ch = 0; ch < NumChannels; ch++) begin
          exp_word.index   = ch[IdxW-1:0];
          exp_word.value   = channel_image[ch];
          exp_word.is_last = (ch == NumChannels - 1);
          pending_channels.push_back(exp_word);
        end
      end
      return;
    end
    ch = int'(frame_pos >> 1) - 1;
    channel_image[ch] = word[ChanW-1:0];
    running_sum = running_sum - {8'h00, prev_byte} - {8'h00, newest_byte};
  endfunction

  task automatic check_channel(input logic [15:0] data, input logic tail);
    chan_word_t exp_word;
    if (pending_channels.size() == 0) begin
      report_mismatch($sformatf("channel word %h with no frame pending", data));
      return;
    end
    exp_word = pending_channels.pop_front();
    if (data[IdxW-1:0] !== exp_word.index)
      report_mismatch($sformatf("channel_index %0d, expected %0d",
                                data[IdxW-1:0], exp_word.index));
    if (data[IdxW +: ChanW] !== exp_word.value)
      report_mismatch($sformatf("channel %0d value %h, expected %h",
                                exp_word.index, data[IdxW +: ChanW], exp_word.value));
    if (tail !== exp_word.is_last)
      report_mismatch($sformatf("channel %0d last %b, expected %b",
                                exp_word.index, tail, exp_word.is_last));
  endtask

  // Predict and check in one process so ordering within an edge is fixed.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) decode_byte(s_tdata);
      if (m_tvalid && m_tready) check_channel(m_tdata, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: no word moved for %0d cycles", WatchdogLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Output side: random stalls, plus a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_request) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        rx_hold_request = 1'b0;
      end
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one byte and return at the edge where it is taken; tvalid stays up.
  task automatic send_byte(input logic [7:0] rx);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic wait_frames_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_channels.size() != 0) @(posedge clk);
  endtask

  // Send a frame body (optionally with its sync) and a checksum offset by sum_error.
  task automatic send_frame(input frame_words_t words, input logic [15:0] sum_error,
                            input bit with_sync);
    logic [15:0] sum;
    int          ch;
    sum = CHECK_INIT;
    if (with_sync) begin
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
    end
    for (ch = 0; ch < NumChannels; ch++) begin
      send_byte(words[ch][7:0]);
      send_byte(words[ch][15:8]);
      sum = sum - {8'h00, words[ch][7:0]} - {8'h00, words[ch][15:8]};
    end
    sum = sum + sum_error;
    send_byte(sum[7:0]);
    send_byte(sum[15:8]);
  endtask

  function automatic frame_words_t random_words();
    frame_words_t words;
    int           ch;
    for (ch = 0; ch < NumChannels; ch++) begin
      case ($urandom_range(0, 7))
        0:       words[ch] = 16'h0000;
        1:       words[ch] = 16'hffff;
        2:       words[ch] = 16'h0fff;
        default: words[ch] = 16'($urandom_range(0, 16'hffff));
      endcase
    end
    return words;
  endfunction

  task automatic test_extreme_frames();
    frame_words_t words;
    int           ch;
    send_frame('0, 16'h0000, 1'b1);
    send_frame({NumChannels{16'hffff}}, 16'h0000, 1'b1);
    for (ch = 0; ch < NumChannels; ch++) words[ch] = ch[0] ? 16'hf000 : 16'h0fff;
    send_frame(words, 16'h0000, 1'b1);
    wait_frames_drained();
  endtask

  task automatic test_bad_checksum();
    send_frame(random_words(), 16'h0001, 1'b1);
    send_frame(random_words(), 16'h8000, 1'b1);
    // Bytes after a rejected checksum are ignored until the next sync.
    send_byte(8'h12);
    send_byte(8'h34);
    send_frame(random_words(), 16'h0000, 1'b1);
    wait_frames_drained();
  endtask

  task automatic test_sync_inside_frame();
    int k;
    // Restart on a pair boundary, mid-frame.
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (k = 0; k < 10; k++) send_byte(8'($urandom_range(0, 255)));
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_frame(random_words(), 16'h0000, 1'b0);
    // Restart straddling a pair: sync first byte lands as a high byte.
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (k = 0; k < 7; k++) send_byte(8'h55);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_frame(random_words(), 16'h0000, 1'b0);
    wait_frames_drained();
  endtask

  task automatic test_idle_bytes();
    // Near-miss sync patterns while idle must not start a frame.
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h41);
    send_byte(8'h20);
    send_byte(8'hff);
    send_byte(8'h00);
    send_frame(random_words(), 16'h0000, 1'b1);
    wait_frames_drained();
  endtask

  task automatic test_backpressure();
    int k;
    rx_hold_request = 1'b1;
    for (k = 0; k < 2; k++) send_frame(random_words(), 16'h0000, 1'b1);
    wait_frames_drained();
  endtask

  task automatic test_random_traffic(input int count);
    int start;
    int pick;
    int k;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(random_words(), 16'h0000, 1'b1);
      end else if (pick < 80) begin
        send_frame(random_words(), 16'($urandom_range(1, 16'hffff)), 1'b1);
      end else if (pick < 90) begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (k = $urandom_range(0, 29); k > 0; k--) send_byte(8'($urandom_range(0, 255)));
      end else begin
        for (k = $urandom_range(1, 6); k > 0; k--) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 9;
    rx_idle_pct = 58;
    test_extreme_frames();
    test_bad_checksum();
    test_sync_inside_frame();
    test_idle_bytes();

    tx_idle_pct = 58;
    rx_idle_pct = 9;
    test_random_traffic(12);
    test_backpressure();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(12);

    wait_frames_drained();
    repeat (SettleCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ibus_pkg.sv
rtl/core/ibus_parse.sv
rtl/core/ibus_burst.sv
rtl/core/ibus_servo_frame_receiver.sv
sim/ibus_servo_frame_receiver_test.sv
